// ===== hdl/mesa_pkg.sv =====
// shared types and constants for the mips execute stage alu
package mesa_pkg;

  localparam int unsigned WordBits   = 32;
  localparam int unsigned RegIdxBits = 5;
  localparam int unsigned OpBits     = 4;

  // packed stream widths, padded to whole bytes
  localparam int unsigned InDataBits  = 152;
  localparam int unsigned OutDataBits = 136;

  typedef enum logic [OpBits-1:0] {
    OP_SLL   = 4'd0,
    OP_SRL   = 4'd1,
    OP_MUL   = 4'd2,
    OP_ADD   = 4'd3,
    OP_SUB   = 4'd4,
    OP_AND   = 4'd5,
    OP_OR    = 4'd6,
    OP_BEQ   = 4'd7,
    OP_ADDI  = 4'd8,
    OP_SLTI  = 4'd9,
    OP_SLTIU = 4'd10,
    OP_ANDI  = 4'd11,
    OP_ORI   = 4'd12,
    OP_LUI   = 4'd13,
    OP_LW    = 4'd14,
    OP_SW    = 4'd15
  } op_t;

  typedef struct packed {
    op_t                   op_code;
    logic [WordBits-1:0]   rs_value;
    logic [WordBits-1:0]   rt_value;
    logic [WordBits-1:0]   immediate;
    logic [4:0]            shift_amount;
    logic [RegIdxBits-1:0] rt_index;
    logic [RegIdxBits-1:0] rd_index;
    logic [WordBits-1:0]   pc_value;
    logic                  use_immediate;
    logic                  dest_is_rd;
    logic                  writes_register;
  } instr_t;

  typedef struct packed {
    logic [WordBits-1:0]   exec_value;
    logic [WordBits-1:0]   product_high;
    logic                  is_multiply;
    logic                  branch_taken;
    logic [WordBits-1:0]   branch_target;
    logic [RegIdxBits-1:0] dest_index;
    logic [WordBits-1:0]   store_data;
    logic                  mark_busy;
  } result_t;

endpackage

// ===== hdl/mesa_alu.sv =====
// combinational execute datapath: alu, multiplier, branch target, destination select
module mesa_alu #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  mesa_pkg::instr_t  instr,
  output mesa_pkg::result_t result
);
  import mesa_pkg::*;

  localparam int unsigned W = DATA_WIDTH;
  // operands are 32-bit values zero-extended to the word; only a 32-bit word
  // sees their top bit as a sign
  localparam logic MulSigned = (DATA_WIDTH == 32);

  logic [W-1:0] rs_w;
  logic [W-1:0] rt_w;
  logic [W-1:0] imm_w;
  logic [W-1:0] opb_w;
  logic [W-1:0] sign_w;
  logic [W-1:0] res_w;
  logic         slt_s;
  logic         slt_u;
  logic         taken;
  logic signed [WordBits:0]     mul_a;
  logic signed [WordBits:0]     mul_b;
  logic signed [2*WordBits+1:0] prod;
  logic [2*WordBits+1:0]        prod_hi;
  logic [WordBits-1:0]          opb32;

  always_comb begin
    rs_w   = W'(instr.rs_value);
    rt_w   = W'(instr.rt_value);
    imm_w  = W'(instr.immediate);
    opb_w  = instr.use_immediate ? imm_w : rt_w;
    opb32  = instr.use_immediate ? instr.immediate : instr.rt_value;
    sign_w = {1'b1, {(W-1){1'b0}}};

    slt_s = (rs_w ^ sign_w) < (imm_w ^ sign_w);
    slt_u = rs_w < imm_w;

    // 33x33 signed product covers every word width in range
    mul_a   = {MulSigned & instr.rs_value[WordBits-1], instr.rs_value};
    mul_b   = {MulSigned & opb32[WordBits-1], opb32};
    prod    = mul_a * mul_b;
    prod_hi = $unsigned(prod) >> W;

    taken = 1'b0;
    case (instr.op_code)
      OP_SLL:                         res_w = opb_w << instr.shift_amount;
      OP_SRL:                         res_w = opb_w >> instr.shift_amount;
      OP_MUL:                         res_w = W'(prod[WordBits-1:0]);
      OP_ADD, OP_ADDI, OP_LW, OP_SW:  res_w = rs_w + opb_w;
      OP_SUB:                         res_w = rs_w - opb_w;
      OP_AND, OP_ANDI:                res_w = rs_w & opb_w;
      OP_OR, OP_ORI:                  res_w = rs_w | opb_w;
      OP_BEQ: begin
        res_w = '0;
        taken = (rs_w == opb_w);
      end
      OP_SLTI:                        res_w = W'(slt_s);
      OP_SLTIU:                       res_w = W'(slt_u);
      OP_LUI:                         res_w = W'({instr.immediate[15:0], 16'h0000});
      default:                        res_w = '0;
    endcase

    result.exec_value    = res_w[WordBits-1:0];
    result.is_multiply   = (instr.op_code == OP_MUL);
    result.product_high  = result.is_multiply ? prod_hi[WordBits-1:0] : '0;
    result.branch_taken  = taken;
    result.branch_target = instr.pc_value + {instr.immediate[WordBits-3:0], 2'b00};
    result.dest_index    = instr.dest_is_rd ? instr.rd_index : instr.rt_index;
    result.store_data    = instr.rt_value;
    result.mark_busy     = instr.writes_register;
  end

endmodule

// ===== hdl/mips_execute_stage_alu.sv =====
// top level of the mips execute stage: input register, alu, result register
//
// channel  | direction | tdata / tuser
// s_*      | in        | decoded instruction; op_code on tuser
// m_*      | out       | execute result; is_multiply on tuser
//
// one transaction accepted per cycle unless a stall on m_tready holds it off; a result
// reaches m_* through the input register, then the result register
// the multiplier and alu sit in one combinational pass between the two registers
// rst clears both valid flags; payload registers are not reset
// a stall on m_tready holds the result and, once the input register is full,
// drops s_tready the same cycle
module mips_execute_stage_alu #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // rs_value, rt_value, immediate, shift_amount, rt_index, rd_index,
  // pc_value, use_immediate, dest_is_rd, writes_register, zero pad
  input  logic [mesa_pkg::InDataBits-1:0]      s_tdata,
  // op_code
  input  logic [mesa_pkg::OpBits-1:0]          s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // exec_value, product_high, branch_taken, branch_target, dest_index,
  // store_data, mark_busy, zero pad
  output logic [mesa_pkg::OutDataBits-1:0]     m_tdata,
  // is_multiply
  output logic                                 m_tuser
);
  import mesa_pkg::*;

  instr_t  in_item;
  instr_t  instr_q;
  logic    instr_valid;
  result_t alu_out;
  result_t result_q;
  logic    result_valid;
  logic    result_free;

  // unpack the instruction transaction
  always_comb begin
    in_item.op_code         = op_t'(s_tuser);
    in_item.rs_value        = s_tdata[31:0];
    in_item.rt_value        = s_tdata[63:32];
    in_item.immediate       = s_tdata[95:64];
    in_item.shift_amount    = s_tdata[100:96];
    in_item.rt_index        = s_tdata[105:101];
    in_item.rd_index        = s_tdata[110:106];
    in_item.pc_value        = s_tdata[142:111];
    in_item.use_immediate   = s_tdata[143];
    in_item.dest_is_rd      = s_tdata[144];
    in_item.writes_register = s_tdata[145];
  end

  // result register can take a new value when empty or being drained
  assign result_free = !result_valid || m_tready;
  assign s_tready    = !instr_valid || result_free;

  mesa_alu #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_alu (
    .instr (instr_q),
    .result(alu_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      instr_valid  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        instr_valid <= s_tvalid;
      end
      if (result_free) begin
        result_valid <= instr_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      instr_q <= in_item;
    end
    if (result_free && instr_valid) begin
      result_q <= alu_out;
    end
  end

  assign m_tvalid = result_valid;
  assign m_tuser  = result_q.is_multiply;
  assign m_tdata  = {1'b0,
                     result_q.mark_busy,
                     result_q.store_data,
                     result_q.dest_index,
                     result_q.branch_target,
                     result_q.branch_taken,
                     result_q.product_high,
                     result_q.exec_value};

endmodule
